// ===== hdl/hxl_pkg.sv =====
// Shared types, character codes and helper functions of the hex text byte loader.
`timescale 1ns / 1ps

package hxl_pkg;

  // Widths and limits.
  localparam int ADDRESS_WIDTH = 32;
  localparam int MAX_CAPACITY  = 65536;
  localparam int CAP_W         = 17;
  localparam int IDX_W         = 16;
  localparam int OUT_ADDR_W    = 32;
  localparam int HEX_BITS      = 4;   // one hex digit, radix 16

  // Result queue; the depth must be a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_X    = 8'h78;

  // Input actions and result kinds.
  localparam logic ACT_CHAR     = 1'b0;
  localparam logic ACT_END      = 1'b1;
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_HEADER_EN = 1'b1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_CAPACITY);

  // Phases of a text.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_FULL   = 2'd2;

  // Line classes.
  localparam logic [1:0] LC_DATA    = 2'd0;
  localparam logic [1:0] LC_COMMENT = 2'd1;
  localparam logic [1:0] LC_ADDR    = 2'd2;

  // Address parser steps.
  localparam logic [2:0] AS_LEAD   = 3'd0;
  localparam logic [2:0] AS_ZERO   = 3'd1;
  localparam logic [2:0] AS_PREFIX = 3'd2;
  localparam logic [2:0] AS_DIGITS = 3'd3;
  localparam logic [2:0] AS_DONE   = 3'd4;

  typedef struct packed {
    logic [1:0]               phase;
    logic                     at_line_start;
    logic [1:0]               line_class;
    logic [2:0]               addr_step;
    logic [HEX_BITS-1:0]      pending_digit;
    logic                     pending_valid;
    logic [CAP_W-1:0]         bytes_written;
    logic [ADDRESS_WIDTH-1:0] address_value;
  } ldr_state_t;

  localparam ldr_state_t STATE_RESET = '{
    phase:         PH_HEADER,
    at_line_start: 1'b1,
    line_class:    LC_DATA,
    addr_step:     AS_LEAD,
    pending_digit: '0,
    pending_valid: 1'b0,
    bytes_written: '0,
    address_value: '0
  };

  typedef struct packed {
    logic                  kind;
    logic [7:0]            byte_value;
    logic [IDX_W-1:0]      byte_index;
    logic [CAP_W-1:0]      byte_count;
    logic [OUT_ADDR_W-1:0] start_address;
    logic                  buffer_full;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [FIFO_LVL_W-1:0] level;
    logic                  not_empty;
    logic                  no_room;
  } fifo_status_t;

  // Returns {is_digit, digit value}.
  function automatic logic [HEX_BITS:0] hex_of(input logic [7:0] c);
    logic [7:0] diff;
    logic [HEX_BITS:0] r;
    r = '0;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff = c - CH_ZERO;
      r = {1'b1, diff[HEX_BITS-1:0]};
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      diff = c - CH_LO_A + 8'd10;
      r = {1'b1, diff[HEX_BITS-1:0]};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      diff = c - CH_UP_A + 8'd10;
      r = {1'b1, diff[HEX_BITS-1:0]};
    end
    return r;
  endfunction

  // Zero acts as one and values above the maximum act as the maximum.
  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] r;
    r = cap;
    if (cap == '0) begin
      r = CAP_W'(1);
    end else if (cap > CAP_W'(MAX_CAPACITY)) begin
      r = CAP_W'(MAX_CAPACITY);
    end
    return r;
  endfunction

endpackage

// ===== hdl/hex_text_byte_loader.sv =====
// Top level of the hex text byte loader: configuration, text state and result queue.
`timescale 1ns / 1ps
//
// The input channel carries one word per text character (in_action = 0, the
// character on in_char_code) or an end-of-text word (in_action = 1). Pairs of
// hex digits on data lines become data result words numbered from zero; lines
// that start with '#' are comments, and in header mode leading '@' lines set
// the start address. An end-of-text word yields a summary word with out_last
// set, preceded by a final data word when a lone digit is still held.
// Each accepted word is decoded in the same cycle against the registered text
// state, and its results are written into a four-entry result queue, which
// registers each result before it is offered. The block takes one input word
// every cycle as long as the queue has room for two more words, so a sustained
// rate of one character per cycle holds while the receiver keeps up; the two
// words an end-of-text word may yield leave the queue one at a time. When the
// receiver stalls, the queue fills and in_stall rises; the head word is held
// unchanged until it is taken. Configuration (cfg_index 0: capacity, 1: header
// enable) is written through cfg_we, by the user only while the block is idle,
// which the block itself does not enforce. Synchronous reset sets the capacity
// to 65536, disables header mode, empties the queue and starts a new text.

module hex_text_byte_loader (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [7:0]                      in_char_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [7:0]                      out_byte_value,
  output logic [hxl_pkg::IDX_W-1:0]       out_byte_index,
  output logic [hxl_pkg::CAP_W-1:0]       out_byte_count,
  output logic [hxl_pkg::OUT_ADDR_W-1:0]  out_start_address,
  output logic                            out_buffer_full,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [hxl_pkg::CAP_W-1:0]       cfg_wdata
);

  logic [hxl_pkg::CAP_W-1:0] cap_r;
  logic                      hdr_en_r;
  hxl_pkg::ldr_state_t       st_r;
  hxl_pkg::ldr_state_t       st_nxt;
  hxl_pkg::result_t          res0;
  hxl_pkg::result_t          res1;
  hxl_pkg::result_t          head;
  hxl_pkg::fifo_status_t     fifo_status;
  logic [1:0]                push_n;
  logic [1:0]                push_acc;
  logic                      in_accept;
  logic                      out_accept;
  logic [hxl_pkg::CAP_W-1:0] cap_eff;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign cap_eff    = hxl_pkg::eff_cap(cap_r);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= hxl_pkg::CAP_RESET;
      hdr_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        hxl_pkg::REG_CAPACITY:  cap_r    <= cfg_wdata;
        hxl_pkg::REG_HEADER_EN: hdr_en_r <= cfg_wdata[0];
        default:                cap_r    <= cap_r;
      endcase
    end
  end

  hxl_decode u_decode (
    .st        (st_r),
    .action    (in_action),
    .char_code (in_char_code),
    .cap_eff   (cap_eff),
    .hdr_en    (hdr_en_r),
    .st_nxt    (st_nxt),
    .res0      (res0),
    .res1      (res1),
    .push_n    (push_n)
  );

  // The text state only moves on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hxl_pkg::STATE_RESET;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  assign push_acc = in_accept ? push_n : 2'd0;

  hxl_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_acc),
    .wr0    (res0),
    .wr1    (res1),
    .pop    (out_accept),
    .head   (head),
    .status (fifo_status)
  );

  assign in_stall          = fifo_status.no_room;
  assign out_valid         = fifo_status.not_empty;
  assign out_kind          = head.kind;
  assign out_byte_value    = head.byte_value;
  assign out_byte_index    = head.byte_index;
  assign out_byte_count    = head.byte_count;
  assign out_start_address = head.start_address;
  assign out_buffer_full   = head.buffer_full;
  assign out_last          = head.last;

`ifndef SYNTHESIS
  // Every end-of-text word pushes a summary as its final result.
  a_end_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == hxl_pkg::ACT_END) |->
      (push_acc == 2'd1 && res0.last) || (push_acc == 2'd2 && res1.last && !res0.last))
    else $error("end of text without a summary word");

  // After an end-of-text word a fresh text starts.
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == hxl_pkg::ACT_END) |=>
      (st_r.bytes_written == '0 && st_r.at_line_start && !st_r.pending_valid))
    else $error("state not restarted after end of text");

  // Once the buffer is full, characters produce no data.
  a_full_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == hxl_pkg::ACT_CHAR && st_r.phase == hxl_pkg::PH_FULL) |->
      (push_acc == 2'd0))
    else $error("data produced after the buffer filled");

  // The queue never holds more words than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_status.level <= hxl_pkg::FIFO_LVL_W'(hxl_pkg::FIFO_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

// ===== hdl/hxl_decode.sv =====
// Next-state and result logic for one accepted character or end-of-text word.
`timescale 1ns / 1ps

module hxl_decode (
  input  hxl_pkg::ldr_state_t                st,
  input  logic                               action,
  input  logic [7:0]                         char_code,
  input  logic [hxl_pkg::CAP_W-1:0]          cap_eff,
  input  logic                               hdr_en,
  output hxl_pkg::ldr_state_t                st_nxt,
  output hxl_pkg::result_t                   res0,
  output hxl_pkg::result_t                   res1,
  output logic [1:0]                         push_n
);

  always_comb begin
    logic [hxl_pkg::HEX_BITS:0] hx;
    logic                       is_digit;
    logic [hxl_pkg::HEX_BITS-1:0] dval;
    logic                       full_now;
    logic [hxl_pkg::CAP_W-1:0]  bytes_inc;
    logic                       full_inc;
    logic                       pv_eff;
    logic                       do_data;
    logic                       do_accum;
    logic                       is_blank;
    hxl_pkg::result_t           data_res;
    hxl_pkg::result_t           sum_res;

    hx        = hxl_pkg::hex_of(char_code);
    is_digit  = hx[hxl_pkg::HEX_BITS];
    dval      = hx[hxl_pkg::HEX_BITS-1:0];
    full_now  = st.bytes_written >= cap_eff;
    bytes_inc = st.bytes_written + hxl_pkg::CAP_W'(1);
    full_inc  = bytes_inc >= cap_eff;
    is_blank  = (char_code == hxl_pkg::CH_SPACE) ||
                (char_code >= hxl_pkg::CH_TAB && char_code <= hxl_pkg::CH_CR);
    pv_eff    = st.pending_valid;
    do_data   = 1'b0;
    do_accum  = 1'b0;

    data_res.kind          = hxl_pkg::KIND_DATA;
    data_res.byte_value    = {st.pending_digit, dval};
    data_res.byte_index    = st.bytes_written[hxl_pkg::IDX_W-1:0];
    data_res.byte_count    = bytes_inc;
    data_res.start_address = hxl_pkg::OUT_ADDR_W'(st.address_value);
    data_res.buffer_full   = full_inc;
    data_res.last          = 1'b0;

    sum_res.kind           = hxl_pkg::KIND_SUMMARY;
    sum_res.byte_value     = '0;
    sum_res.byte_index     = '0;
    sum_res.byte_count     = st.bytes_written;
    sum_res.start_address  = hxl_pkg::OUT_ADDR_W'(st.address_value);
    sum_res.buffer_full    = full_now;
    sum_res.last           = 1'b1;

    st_nxt = st;
    res0   = data_res;
    res1   = sum_res;
    push_n = 2'd0;

    if (action == hxl_pkg::ACT_END) begin
      if (st.phase == hxl_pkg::PH_DATA && st.pending_valid && !full_now) begin
        // The lone digit becomes a byte of its own before the summary.
        res0.byte_value     = {{hxl_pkg::HEX_BITS{1'b0}}, st.pending_digit};
        res1.byte_count     = bytes_inc;
        res1.buffer_full    = full_inc;
        push_n              = 2'd2;
      end else begin
        res0   = sum_res;
        push_n = 2'd1;
      end
      st_nxt = hxl_pkg::STATE_RESET;
    end else if (st.phase != hxl_pkg::PH_FULL) begin
      if (st.at_line_start) begin
        st_nxt.at_line_start = 1'b0;
        if (st.phase == hxl_pkg::PH_HEADER && hdr_en && char_code == hxl_pkg::CH_HASH) begin
          st_nxt.line_class = hxl_pkg::LC_COMMENT;
        end else if (st.phase == hxl_pkg::PH_HEADER && hdr_en &&
                     char_code == hxl_pkg::CH_AT) begin
          st_nxt.line_class    = hxl_pkg::LC_ADDR;
          st_nxt.address_value = '0;
          st_nxt.addr_step     = hxl_pkg::AS_LEAD;
        end else begin
          st_nxt.phase = hxl_pkg::PH_DATA;
          if (char_code == hxl_pkg::CH_HASH) begin
            st_nxt.line_class = hxl_pkg::LC_COMMENT;
          end else begin
            // A digit left over from the previous line is dropped here.
            st_nxt.line_class    = hxl_pkg::LC_DATA;
            st_nxt.pending_valid = 1'b0;
            pv_eff               = 1'b0;
            do_data              = 1'b1;
          end
        end
      end else if (st.line_class == hxl_pkg::LC_DATA) begin
        do_data = 1'b1;
      end else if (st.line_class == hxl_pkg::LC_ADDR) begin
        case (st.addr_step)
          hxl_pkg::AS_LEAD: begin
            if (is_blank) begin
              do_accum = 1'b0;
            end else if (char_code == hxl_pkg::CH_ZERO) begin
              st_nxt.addr_step = hxl_pkg::AS_ZERO;
            end else begin
              do_accum = 1'b1;
            end
          end
          hxl_pkg::AS_ZERO: begin
            if (char_code == hxl_pkg::CH_LO_X || char_code == hxl_pkg::CH_UP_X) begin
              st_nxt.addr_step = hxl_pkg::AS_PREFIX;
            end else begin
              do_accum = 1'b1;
            end
          end
          hxl_pkg::AS_PREFIX, hxl_pkg::AS_DIGITS: begin
            do_accum = 1'b1;
          end
          default: begin
            do_accum = 1'b0;
          end
        endcase
        if (do_accum) begin
          if (is_digit) begin
            st_nxt.address_value =
              {st.address_value[hxl_pkg::ADDRESS_WIDTH-hxl_pkg::HEX_BITS-1:0], dval};
            st_nxt.addr_step = hxl_pkg::AS_DIGITS;
          end else begin
            st_nxt.addr_step = hxl_pkg::AS_DONE;
          end
        end
      end

      if (do_data) begin
        if (full_now) begin
          st_nxt.phase = hxl_pkg::PH_FULL;
        end else if (is_digit) begin
          if (pv_eff) begin
            st_nxt.pending_valid = 1'b0;
            st_nxt.bytes_written = bytes_inc;
            push_n               = 2'd1;
            if (full_inc) begin
              st_nxt.phase = hxl_pkg::PH_FULL;
            end
          end else begin
            st_nxt.pending_digit = dval;
            st_nxt.pending_valid = 1'b1;
          end
        end
      end

      if (char_code == hxl_pkg::CH_NEWLINE) begin
        st_nxt.at_line_start = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/hxl_out_fifo.sv =====
// Small result queue that takes up to two result words per cycle and hands out one.
`timescale 1ns / 1ps

module hxl_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_n,
  input  hxl_pkg::result_t      wr0,
  input  hxl_pkg::result_t      wr1,
  input  logic                  pop,
  output hxl_pkg::result_t      head,
  output hxl_pkg::fifo_status_t status
);

  hxl_pkg::result_t                mem_r [hxl_pkg::FIFO_DEPTH];
  logic [hxl_pkg::FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [hxl_pkg::FIFO_PTR_W-1:0]  wr_ptr_nxt;
  logic [hxl_pkg::FIFO_PTR_W-1:0]  wr_ptr_plus1;
  logic [hxl_pkg::FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [hxl_pkg::FIFO_PTR_W-1:0]  rd_ptr_nxt;
  logic [hxl_pkg::FIFO_LVL_W-1:0]  level_r;
  logic [hxl_pkg::FIFO_LVL_W-1:0]  level_nxt;

  always_comb begin
    wr_ptr_plus1 = wr_ptr_r + hxl_pkg::FIFO_PTR_W'(1);
    wr_ptr_nxt   = wr_ptr_r + hxl_pkg::FIFO_PTR_W'(push_n);
    rd_ptr_nxt   = pop ? rd_ptr_r + hxl_pkg::FIFO_PTR_W'(1) : rd_ptr_r;
    level_nxt    = level_r + hxl_pkg::FIFO_LVL_W'(push_n) - hxl_pkg::FIFO_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= wr0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_plus1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign head             = mem_r[rd_ptr_r];
  assign status.level     = level_r;
  assign status.not_empty = level_r != '0;
  // Room for two more words is kept so an end-of-text word can always be taken.
  assign status.no_room   = level_r > hxl_pkg::FIFO_LVL_W'(hxl_pkg::FIFO_DEPTH - 2);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the hex text byte loader.
`timescale 1ns / 1ps

module tb;

  // Extra character codes used only by the stimulus.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // The scoreboard keeps its own copy of the loader state and registers.
  // Every accepted input word is decoded here into the result words it should
  // cause, and every result word leaving the block is compared against the
  // oldest of them.
  class loader_scoreboard;
    logic [hxl_pkg::CAP_W-1:0]         cap_reg;
    logic                              hdr_en;
    logic [1:0]                        ph;
    logic                              line_start;
    logic [1:0]                        lclass;
    logic [2:0]                        astep;
    logic [3:0]                        pdig;
    logic                              pval;
    logic [hxl_pkg::CAP_W-1:0]         nbytes;
    logic [hxl_pkg::ADDRESS_WIDTH-1:0] addr;
    hxl_pkg::result_t                  due_results[$];
    int                                errors;

    function new();
      cap_reg = hxl_pkg::CAP_RESET;
      hdr_en = 1'b0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      ph = hxl_pkg::PH_HEADER;
      line_start = 1'b1;
      lclass = hxl_pkg::LC_DATA;
      astep = hxl_pkg::AS_LEAD;
      pdig = '0;
      pval = 1'b0;
      nbytes = '0;
      addr = '0;
    endfunction

    function void set_reg(logic idx, logic [hxl_pkg::CAP_W-1:0] val);
      if (idx == hxl_pkg::REG_CAPACITY) begin
        cap_reg = val;
      end else begin
        hdr_en = val[0];
      end
    endfunction

    // Zero behaves as one, anything beyond the maximum as the maximum.
    function logic [hxl_pkg::CAP_W-1:0] cap_limit();
      logic [hxl_pkg::CAP_W-1:0] c;
      c = cap_reg;
      if (c == '0) begin
        c = hxl_pkg::CAP_W'(1);
      end else if (c > hxl_pkg::CAP_W'(hxl_pkg::MAX_CAPACITY)) begin
        c = hxl_pkg::CAP_W'(hxl_pkg::MAX_CAPACITY);
      end
      return c;
    endfunction

    // Returns 16 for anything that is not a hex digit.
    function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - "0";
      if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
      if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
      return 16;
    endfunction

    function void push_result(logic kind, logic [7:0] val, logic [hxl_pkg::IDX_W-1:0] idx,
                              logic last);
      hxl_pkg::result_t r;
      r.kind = kind;
      r.byte_value = val;
      r.byte_index = idx;
      r.byte_count = nbytes;
      r.start_address = addr;
      r.buffer_full = (nbytes >= cap_limit());
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void emit_byte(logic [7:0] val);
      logic [hxl_pkg::CAP_W-1:0] idx;
      idx = nbytes;
      nbytes = nbytes + hxl_pkg::CAP_W'(1);
      if (nbytes >= cap_limit()) ph = hxl_pkg::PH_FULL;
      push_result(hxl_pkg::KIND_DATA, val, idx[hxl_pkg::IDX_W-1:0], 1'b0);
    endfunction

    function void data_char(logic [7:0] c);
      int d;
      if (nbytes >= cap_limit()) begin
        // Covers a capacity lowered below the count while a text was open.
        ph = hxl_pkg::PH_FULL;
        return;
      end
      d = digit_value(c);
      if (d < 16) begin
        if (pval) begin
          pval = 1'b0;
          emit_byte({pdig, 4'(d)});
        end else begin
          pdig = 4'(d);
          pval = 1'b1;
        end
      end
    endfunction

    // Address parsing: leading blanks, an optional 0x prefix, then hex digits
    // shifted in with wraparound; the first other character ends the number.
    function void addr_char(logic [7:0] c);
      int d;
      logic blank;
      d = digit_value(c);
      blank = (c == hxl_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
      case (astep)
        hxl_pkg::AS_LEAD: begin
          if (blank) return;
          if (c == hxl_pkg::CH_ZERO) begin
            astep = hxl_pkg::AS_ZERO;
            return;
          end
        end
        hxl_pkg::AS_ZERO: begin
          if (c == hxl_pkg::CH_LO_X || c == hxl_pkg::CH_UP_X) begin
            astep = hxl_pkg::AS_PREFIX;
            return;
          end
        end
        hxl_pkg::AS_PREFIX, hxl_pkg::AS_DIGITS: ;
        default: return;
      endcase
      if (d < 16) begin
        addr = {addr[hxl_pkg::ADDRESS_WIDTH-5:0], 4'(d)};
        astep = hxl_pkg::AS_DIGITS;
      end else begin
        astep = hxl_pkg::AS_DONE;
      end
    endfunction

    // A data line drops any lone digit left from the line before.
    function void begin_data_line(logic [7:0] c);
      if (c == hxl_pkg::CH_HASH) begin
        lclass = hxl_pkg::LC_COMMENT;
        return;
      end
      lclass = hxl_pkg::LC_DATA;
      pval = 1'b0;
      data_char(c);
    endfunction

    // Called for every input word accepted by the block.
    function void decode_word(logic act, logic [7:0] c);
      if (act == hxl_pkg::ACT_END) begin
        // A lone digit still held at end of text becomes a byte of its own.
        if (ph == hxl_pkg::PH_DATA && pval && nbytes < cap_limit()) begin
          pval = 1'b0;
          emit_byte({4'd0, pdig});
        end
        push_result(hxl_pkg::KIND_SUMMARY, 8'd0, '0, 1'b1);
        restart();
        return;
      end
      if (ph == hxl_pkg::PH_FULL) return;
      if (line_start) begin
        line_start = 1'b0;
        if (ph == hxl_pkg::PH_HEADER && hdr_en) begin
          if (c == hxl_pkg::CH_HASH) begin
            lclass = hxl_pkg::LC_COMMENT;
          end else if (c == hxl_pkg::CH_AT) begin
            lclass = hxl_pkg::LC_ADDR;
            addr = '0;
            astep = hxl_pkg::AS_LEAD;
          end else begin
            ph = hxl_pkg::PH_DATA;
            begin_data_line(c);
          end
        end else begin
          ph = hxl_pkg::PH_DATA;
          begin_data_line(c);
        end
      end else if (lclass == hxl_pkg::LC_DATA) begin
        data_char(c);
      end else if (lclass == hxl_pkg::LC_ADDR) begin
        addr_char(c);
      end
      if (c == hxl_pkg::CH_NEWLINE) line_start = 1'b1;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    // Called for every result word taken from the block.
    function void check_result(hxl_pkg::result_t got);
      hxl_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result word with none due: kind %0d value %0h index %0d",
               got.kind, got.byte_value, got.byte_index);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.byte_value !== want.byte_value) begin
        $error("byte_value: expected %0h, got %0h", want.byte_value, got.byte_value);
        errors++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        errors++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
        errors++;
      end
      if (got.start_address !== want.start_address) begin
        $error("start_address: expected %0h, got %0h", want.start_address,
               got.start_address);
        errors++;
      end
      if (got.buffer_full !== want.buffer_full) begin
        $error("buffer_full: expected %0d, got %0d", want.buffer_full, got.buffer_full);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // All inputs of the block start at known values.
  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               in_action = hxl_pkg::ACT_CHAR;
  logic [7:0]                         in_char_code = 8'd0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               out_kind;
  logic [7:0]                         out_byte_value;
  logic [hxl_pkg::IDX_W-1:0]          out_byte_index;
  logic [hxl_pkg::CAP_W-1:0]          out_byte_count;
  logic [hxl_pkg::OUT_ADDR_W-1:0]     out_start_address;
  logic                               out_buffer_full;
  logic                               out_last;
  logic                               cfg_we = 1'b0;
  logic                               cfg_index = hxl_pkg::REG_CAPACITY;
  logic [hxl_pkg::CAP_W-1:0]          cfg_wdata = '0;

  loader_scoreboard sb;
  int  words_sent = 0;
  // While calm is set neither side idles, giving a stretch at full rate.
  bit  calm = 1'b0;

  hex_text_byte_loader dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_byte_index   (out_byte_index),
    .out_byte_count   (out_byte_count),
    .out_start_address(out_start_address),
    .out_buffer_full  (out_buffer_full),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: everything is sampled as it stood at the clock edge, then the
  // stall for the next cycle is chosen at random.
  always @(posedge clk) begin
    hxl_pkg::result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_kind;
      got.byte_value = out_byte_value;
      got.byte_index = out_byte_index;
      got.byte_count = out_byte_count;
      got.start_address = out_start_address;
      got.buffer_full = out_buffer_full;
      got.last = out_last;
      sb.check_result(got);
    end
    out_stall <= !calm && ($urandom_range(99) < 29);
  end

  // Offers one word, with random idle cycles in front of it, and holds it
  // until the block takes it.
  task automatic send_word(logic act, logic [7:0] c);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_char_code <= c;
    do @(posedge clk); while (in_stall);
    words_sent++;
    sb.decode_word(act, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(hxl_pkg::ACT_CHAR, s[i]);
  endtask

  // Stops the sender until every due result has arrived, then lets a few
  // cycles pass so that a word causing no result has cleared the block too.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only call while the block is idle. The write enable drops before the next
  // write can raise it again.
  task automatic write_reg(logic idx, logic [hxl_pkg::CAP_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Mostly small capacities so that the buffer fills often, plus the extremes.
  function automatic logic [hxl_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(9))
      0: return '0;
      1: return hxl_pkg::CAP_W'(hxl_pkg::MAX_CAPACITY);
      2: return '1;
      3: return hxl_pkg::CAP_W'($urandom_range(hxl_pkg::MAX_CAPACITY + 1, 131071));
      4: return hxl_pkg::CAP_W'($urandom_range(1, hxl_pkg::MAX_CAPACITY));
      default: return hxl_pkg::CAP_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'(hxl_pkg::CH_ZERO + v);
    if ($urandom_range(1)) return 8'(hxl_pkg::CH_LO_A + v - 10);
    return 8'(hxl_pkg::CH_UP_A + v - 10);
  endfunction

  function automatic logic [7:0] separator();
    case ($urandom_range(3))
      0: return hxl_pkg::CH_SPACE;
      1: return hxl_pkg::CH_TAB;
      2: return CH_COMMA;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // An address header line with random spacing, prefix, sign and length.
  // Long digit runs check that the address wraps instead of saturating.
  task automatic address_line();
    int n;
    send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_AT);
    n = $urandom_range(0, 2);
    repeat (n) send_word(hxl_pkg::ACT_CHAR,
                         $urandom_range(1) ? hxl_pkg::CH_SPACE : 8'($urandom_range(9, 13)));
    if ($urandom_range(9) == 0) begin
      send_word(hxl_pkg::ACT_CHAR, $urandom_range(1) ? CH_MINUS : CH_PLUS);
    end
    if ($urandom_range(1)) begin
      send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_ZERO);
      send_word(hxl_pkg::ACT_CHAR, $urandom_range(1) ? hxl_pkg::CH_LO_X : hxl_pkg::CH_UP_X);
    end
    n = $urandom_range(0, 11);
    repeat (n) send_word(hxl_pkg::ACT_CHAR, hex_char($urandom_range(15)));
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(hxl_pkg::ACT_CHAR, 8'($urandom_range(32, 255)));
    end
    send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_NEWLINE);
  endtask

  task automatic data_line();
    int n;
    n = $urandom_range(0, 16);
    for (int i = 0; i < n; i++) begin
      send_word(hxl_pkg::ACT_CHAR, hex_char($urandom_range(15)));
      if ($urandom_range(99) < 30) send_word(hxl_pkg::ACT_CHAR, separator());
    end
    send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_NEWLINE);
  endtask

  // One text: optional header lines, a mix of mostly well-formed data lines
  // with comments, lone digits, noise and empty lines, then end of text.
  task automatic random_text();
    int lines;
    int r;
    int n;
    lines = $urandom_range(0, 3);
    for (int i = 0; i < lines; i++) begin
      if ($urandom_range(9) < 7) begin
        address_line();
      end else begin
        send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_HASH);
        send_word(hxl_pkg::ACT_CHAR, 8'($urandom_range(0, 255)));
        send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_NEWLINE);
      end
    end
    lines = $urandom_range(1, 6);
    for (int i = 0; i < lines; i++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        data_line();
      end else if (r < 70) begin
        send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_HASH);
        send_word(hxl_pkg::ACT_CHAR, hex_char($urandom_range(15)));
        send_word(hxl_pkg::ACT_CHAR, hex_char($urandom_range(15)));
        send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_NEWLINE);
      end else if (r < 78) begin
        send_word(hxl_pkg::ACT_CHAR, hex_char($urandom_range(15)));
        send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_NEWLINE);
      end else if (r < 88) begin
        n = $urandom_range(1, 12);
        repeat (n) send_word(hxl_pkg::ACT_CHAR, 8'($urandom_range(0, 255)));
        send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_NEWLINE);
      end else begin
        send_word(hxl_pkg::ACT_CHAR, hxl_pkg::CH_NEWLINE);
      end
      // Now and then the capacity is lowered in the middle of a text, which
      // may leave it below the byte count already reached.
      if ($urandom_range(99) < 3) begin
        drain();
        write_reg(hxl_pkg::REG_CAPACITY, hxl_pkg::CAP_W'($urandom_range(0, 8)));
      end
    end
    // A trailing fragment without newline, often an odd number of digits.
    if ($urandom_range(1)) begin
      n = $urandom_range(1, 3);
      repeat (n) send_word(hxl_pkg::ACT_CHAR, hex_char($urandom_range(15)));
    end
    send_word(hxl_pkg::ACT_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: a comment line, a lone digit dropped at the next
    // line start, and a lone digit that becomes a byte at end of text.
    send_text("#1\n7\n9");
    send_word(hxl_pkg::ACT_END, 8'hFF);
    drain();

    // Header mode with capacity zero (acts as one): the address line has a
    // blank and a 0x prefix, an empty line starts the data, and the buffer
    // fills after one byte so the rest is ignored.
    write_reg(hxl_pkg::REG_HEADER_EN, hxl_pkg::CAP_W'(1));
    write_reg(hxl_pkg::REG_CAPACITY, '0);
    send_text("@ 0x8\n\nabc");
    send_word(hxl_pkg::ACT_END, 8'h00);
    drain();

    // Capacity above the maximum; text ends while still in the header.
    write_reg(hxl_pkg::REG_CAPACITY, '1);
    send_text("@");
    send_word(hxl_pkg::ACT_END, 8'h5A);
    drain();

    while (words_sent < 2000) begin
      if ($urandom_range(99) < 30) begin
        drain();
        if ($urandom_range(2) != 0) write_reg(hxl_pkg::REG_CAPACITY, pick_capacity());
        if ($urandom_range(2) != 0) begin
          write_reg(hxl_pkg::REG_HEADER_EN, hxl_pkg::CAP_W'($urandom_range(1)));
        end
      end
      calm = (words_sent > 900 && words_sent < 1300);
      random_text();
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
